[design/tabf_pkg.sv]
`default_nettype none

package tabf_pkg;

  // Default sizing
  localparam int SLOT_COUNT_DEF   = 8;
  localparam int MAX_CHANNELS_DEF = 2;
  localparam int MAX_FRAMES_DEF   = 256;
  localparam int SAMPLE_BITS_DEF  = 24;

  // Fixed field widths
  localparam int WANT_CH_W  = 8;
  localparam int WANT_FR_W  = 16;
  localparam int WANT_LEN_W = WANT_CH_W + WANT_FR_W;
  localparam int STAMP_W    = 48;
  localparam int TALLY_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int CH_REG_W   = 2;

  // Register reset values (before clamping)
  localparam int CFG_CHANNELS_RESET = 2;
  localparam int CFG_FRAMES_RESET   = 256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 1'b1;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERRUN = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctl_cmd_t;

endpackage

`default_nettype wire

[design/tabf_ctrl.sv]
`default_nettype none

module tabf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output tabf_pkg::ctl_cmd_t     cmd
);

  tabf_pkg::state_t state, state_next;
  logic             m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tabf_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tabf_pkg::S_IDLE: begin
        if (s_tvalid) state_next = tabf_pkg::S_EXEC;
      end
      tabf_pkg::S_EXEC: begin
        state_next = tabf_pkg::S_FETCH;
      end
      tabf_pkg::S_FETCH: begin
        if (!m_tvalid || m_tready) state_next = tabf_pkg::S_IDLE;
      end
      default: begin
        state_next = tabf_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      tabf_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      tabf_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      tabf_pkg::S_FETCH: begin
        if (!m_tvalid || m_tready) begin
          cmd.load      = 1'b1;
          m_tvalid_next = 1'b1;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/tabf_datapath.sv]
`default_nettype none

module tabf_datapath #(
  parameter int SLOT_COUNT   = tabf_pkg::SLOT_COUNT_DEF,
  parameter int MAX_CHANNELS = tabf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_FRAMES   = tabf_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS  = tabf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tabf_pkg::ctl_cmd_t                    cmd,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tabf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tabf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_req_type,
  input  wire logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic [tabf_pkg::WANT_CH_W-1:0]        in_want_channels,
  input  wire logic [tabf_pkg::WANT_FR_W-1:0]        in_want_frames,
  output logic signed [SAMPLE_BITS-1:0]              out_sample,
  output logic [tabf_pkg::STAMP_W-1:0]               out_stamp,
  output logic                                       out_last,
  output logic [tabf_pkg::STATUS_W-1:0]              out_status,
  output logic [tabf_pkg::TALLY_W-1:0]               out_tally
);

  localparam int SLOT_SIZE = MAX_CHANNELS * MAX_FRAMES;
  localparam int DEPTH     = SLOT_COUNT * SLOT_SIZE;
  localparam int AW        = $clog2(DEPTH);
  localparam int SW        = $clog2(SLOT_COUNT);
  localparam int LW        = $clog2(SLOT_SIZE + 1);
  localparam int CW        = $clog2(MAX_CHANNELS + 1);
  localparam int FW        = $clog2(MAX_FRAMES + 1);
  localparam int RW        = tabf_pkg::WANT_LEN_W;
  localparam int C_RST     = (tabf_pkg::CFG_CHANNELS_RESET > MAX_CHANNELS) ?
                             MAX_CHANNELS : tabf_pkg::CFG_CHANNELS_RESET;
  localparam int F_RST     = (tabf_pkg::CFG_FRAMES_RESET > MAX_FRAMES) ?
                             MAX_FRAMES : tabf_pkg::CFG_FRAMES_RESET;

  // clamped configuration
  logic [CW-1:0] c_eff, c_clamp;
  logic [FW-1:0] f_eff, f_clamp;

  // captured item
  logic                   req_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   match_q;
  logic [RW-1:0]          want_len_q;
  logic [LW-1:0]          len_q;

  // ring state
  logic [SW-1:0]               ws, rs, ws_inc, rs_inc;
  logic [LW-1:0]               wpos, wpos_inc;
  logic [RW-1:0]               rpos, rpos_inc, rlen, len_new, rlen_cur;
  logic                        r_under, under_new, u_cur, rd_first;
  logic [tabf_pkg::STAMP_W-1:0] running;
  logic [tabf_pkg::TALLY_W-1:0] tally;
  logic                        full, w_end, r_end;
  logic [AW-1:0]               waddr, raddr;

  // pending result
  logic [tabf_pkg::STATUS_W-1:0] pend_status;
  logic                          pend_last;
  logic                          pend_mem;

  // storage
  logic [SAMPLE_BITS-1:0]       store [DEPTH];
  logic [tabf_pkg::STAMP_W-1:0] stamps [SLOT_COUNT];
  logic [SAMPLE_BITS-1:0]       rd_sample;
  logic [tabf_pkg::STAMP_W-1:0] rd_stamp;

  logic do_write, do_stamp, do_read;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data[tabf_pkg::CH_REG_W-1:0] == '0) begin
      c_clamp = CW'(1);
    end else if (32'(cfg_data[tabf_pkg::CH_REG_W-1:0]) > MAX_CHANNELS) begin
      c_clamp = CW'(MAX_CHANNELS);
    end else begin
      c_clamp = CW'(cfg_data[tabf_pkg::CH_REG_W-1:0]);
    end
    if (cfg_data == '0) begin
      f_clamp = FW'(1);
    end else if (32'(cfg_data) > MAX_FRAMES) begin
      f_clamp = FW'(MAX_FRAMES);
    end else begin
      f_clamp = FW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_eff <= CW'(C_RST);
      f_eff <= FW'(F_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        tabf_pkg::REG_CHANNELS: c_eff <= c_clamp;
        tabf_pkg::REG_FRAMES:   f_eff <= f_clamp;
        default: ;
      endcase
    end
  end

  // capture: shape products and request match are registered here
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q      <= in_req_type;
      sample_q   <= in_sample;
      match_q    <= (tabf_pkg::WANT_CH_W'(c_eff) == in_want_channels) &&
                    (tabf_pkg::WANT_FR_W'(f_eff) == in_want_frames);
      want_len_q <= RW'(in_want_channels * in_want_frames);
      len_q      <= LW'(c_eff * f_eff);
    end
  end

  // execute-stage decisions
  always_comb begin
    ws_inc    = (ws == SW'(SLOT_COUNT - 1)) ? '0 : ws + 1'b1;
    rs_inc    = (rs == SW'(SLOT_COUNT - 1)) ? '0 : rs + 1'b1;
    full      = (wpos == '0) && (ws_inc == rs);
    wpos_inc  = wpos + 1'b1;
    w_end     = wpos_inc >= len_q;
    rd_first  = (rpos == '0);
    under_new = !match_q || (rs == ws);
    if (under_new) begin
      len_new = (want_len_q == '0) ? RW'(1) : want_len_q;
    end else begin
      len_new = RW'(len_q);
    end
    u_cur     = rd_first ? under_new : r_under;
    rlen_cur  = rd_first ? len_new : rlen;
    rpos_inc  = rpos + 1'b1;
    r_end     = rpos_inc >= rlen_cur;
    waddr     = AW'(ws) * AW'(SLOT_SIZE) + AW'(wpos);
    raddr     = AW'(rs) * AW'(SLOT_SIZE) + AW'(rpos[LW-1:0]);
    do_write  = cmd.exec && (req_q == tabf_pkg::REQ_WRITE) && !full;
    do_stamp  = do_write && w_end;
    do_read   = cmd.exec && (req_q == tabf_pkg::REQ_READ) && !u_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws          <= '0;
      rs          <= '0;
      wpos        <= '0;
      rpos        <= '0;
      rlen        <= '0;
      r_under     <= 1'b0;
      running     <= '0;
      tally       <= '0;
      pend_status <= tabf_pkg::ST_OK;
      pend_last   <= 1'b0;
      pend_mem    <= 1'b0;
    end else if (cmd.exec) begin
      if (req_q == tabf_pkg::REQ_WRITE) begin
        pend_mem <= 1'b0;
        if (full) begin
          pend_status <= tabf_pkg::ST_FULL;
          pend_last   <= 1'b0;
        end else begin
          pend_status <= tabf_pkg::ST_OK;
          pend_last   <= w_end;
          if (w_end) begin
            ws      <= ws_inc;
            wpos    <= '0;
            running <= running + tabf_pkg::STAMP_W'(f_eff);
          end else begin
            wpos <= wpos_inc;
          end
        end
      end else begin
        pend_status <= u_cur ? tabf_pkg::ST_UNDERRUN : tabf_pkg::ST_OK;
        pend_mem    <= !u_cur;
        pend_last   <= r_end;
        if (rd_first) begin
          r_under <= under_new;
          rlen    <= len_new;
          if (under_new && (tally != '1)) tally <= tally + 1'b1;
        end
        if (r_end) begin
          rpos    <= '0;
          r_under <= 1'b0;
          if (!u_cur) rs <= rs_inc;
        end else begin
          rpos <= rpos_inc;
        end
      end
    end
  end

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) store[waddr] <= sample_q;
    if (do_read) rd_sample <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (do_stamp) stamps[ws] <= running;
    if (do_read) rd_stamp <= stamps[rs];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_sample <= pend_mem ? rd_sample : '0;
      out_stamp  <= pend_mem ? rd_stamp : '0;
      out_last   <= pend_last;
      out_status <= pend_status;
      out_tally  <= tally;
    end
  end

endmodule

`default_nettype wire

[design/timestamped_audio_block_fifo_top.sv]
`default_nettype none

// Ring of SLOT_COUNT audio blocks (one slot always kept empty), each block
// channels_in_use x frames_in_use Q1.23 samples stored channel-major. Every
// input item is either a producer write of one sample (tuser = 0) or a
// consumer read of one sample (tuser = 1), and every item yields exactly one
// result item. A write that would start a block while the ring is full is
// refused (status 1). The last write of a block stamps it with a running
// 48-bit sample count, which then advances by the frame count. A read block
// whose requested shape does not match the (clamped) configuration, or that
// finds the ring empty, returns zeros for want_channels*want_frames items
// (at least one) with status 2 and bumps a saturating 16-bit underrun count.
// Each item passes three steps - capture (shape products), execute
// (ring state update, store write or read issue) and fetch (registered store
// read into the result register). The result register decouples the two
// sides: a new item is taken while the previous result still waits, and the
// block only holds in fetch if the result register is still occupied. The
// sample store is not cleared at reset; reading a slot region that was never
// written (frame/channel count grown between write and read) returns
// undefined data. Configuration writes are always ready and take effect on
// the next item.
module timestamped_audio_block_fifo_top #(
  parameter int SLOT_COUNT   = tabf_pkg::SLOT_COUNT_DEF,
  parameter int MAX_CHANNELS = tabf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_FRAMES   = tabf_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS  = tabf_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W        = SAMPLE_BITS + tabf_pkg::WANT_LEN_W,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = SAMPLE_BITS + tabf_pkg::STAMP_W + tabf_pkg::TALLY_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input item
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [IN_TDATA_W-1:0]             s_tdata,  // sample_in, want_channels, want_frames
  input  wire logic                              s_tuser,  // req_type
  // result item
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [OUT_TDATA_W-1:0]                 m_tdata,  // sample_out, sample_start, underrun_total
  output logic                                   m_tlast,  // block_last
  output logic [tabf_pkg::STATUS_W-1:0]          m_tuser,  // status
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tabf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tabf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tabf_pkg::ctl_cmd_t cmd;

  logic signed [SAMPLE_BITS-1:0]       in_sample;
  logic [tabf_pkg::WANT_CH_W-1:0]      in_want_channels;
  logic [tabf_pkg::WANT_FR_W-1:0]      in_want_frames;
  logic signed [SAMPLE_BITS-1:0]       out_sample;
  logic [tabf_pkg::STAMP_W-1:0]        out_stamp;
  logic [tabf_pkg::TALLY_W-1:0]        out_tally;

  assign in_sample        = s_tdata[SAMPLE_BITS-1:0];
  assign in_want_channels = s_tdata[SAMPLE_BITS +: tabf_pkg::WANT_CH_W];
  assign in_want_frames   = s_tdata[SAMPLE_BITS + tabf_pkg::WANT_CH_W +: tabf_pkg::WANT_FR_W];

  assign m_tdata = OUT_TDATA_W'({out_tally, out_stamp, out_sample});

  tabf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  tabf_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FRAMES   (MAX_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (s_tuser),
    .in_sample        (in_sample),
    .in_want_channels (in_want_channels),
    .in_want_frames   (in_want_frames),
    .out_sample       (out_sample),
    .out_stamp        (out_stamp),
    .out_last         (m_tlast),
    .out_status       (m_tuser),
    .out_tally        (out_tally)
  );

  // one item in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in flight");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == tabf_pkg::ST_OK || m_tuser == tabf_pkg::ST_FULL ||
                  m_tuser == tabf_pkg::ST_UNDERRUN))
    else $error("undefined status code");

  // a refused write never closes a block
  a_refused_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tabf_pkg::ST_FULL |-> !m_tlast)
    else $error("refused write marked as block end");

  // underrun items carry zero sample and zero stamp
  a_underrun_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tabf_pkg::ST_UNDERRUN |->
      m_tdata[SAMPLE_BITS + tabf_pkg::STAMP_W - 1:0] == '0)
    else $error("underrun item with nonzero data");

endmodule

`default_nettype wire
